/* hw/rtl/pls_pkg.sv */
// Package for the positional list store: field widths, operation codes,
// reset values and the control bundle broadcast to every storage cell.
// No dependencies.
package pls_pkg;

    localparam int FUNC_W    = 2;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // Broadcast to all cells in the cycle an item is accepted.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

/* hw/rtl/pls_cell.sv */
// One storage cell of the list: holds a single entry and loads from its
// lower or upper neighbor when an insert or a remove moves the list.
// Depends on pls_pkg.
module pls_cell import pls_pkg::*; #(
    parameter int unsigned INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_prev_data,
    input  logic [DATA_W-1:0] i_next_data,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_sel_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [31:0]       w_pos;
    logic              w_at_pos;
    logic              w_above;

    assign w_pos    = 32'(i_ctl.position);
    assign w_at_pos = (w_pos == INDEX);
    assign w_above  = (w_pos < INDEX);

    // Cells past the end of the list may take stale data; they are never read.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && w_above) begin
            n_data = i_prev_data;
        end else if (i_ctl.ins && w_at_pos) begin
            n_data = i_ctl.value;
        end else if (i_ctl.rem && (w_at_pos || w_above)) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_sel_data = w_at_pos ? r_data : '0;

endmodule

/* hw/rtl/positional_list_store_unit.sv */
// Top level of the positional list store: a row of storage cells, the entry
// count, the capacity register and the registered result stage.
// Depends on pls_pkg and pls_cell.

// The list lives in a row of DEPTH cells, one entry each. An insert or a
// remove shifts every affected entry by one place in the same clock, each
// cell loading from its neighbor, so one item is accepted per clock while
// ready; its result is loaded into the output register on acceptance. A read
// is a one-hot select across the cells. The input side stays ready while
// the output register is empty or its result is being taken. The capacity
// register limits the count to min(capacity, DEPTH); lowering it below the
// current count keeps the entries and only refuses further inserts.
module positional_list_store_unit import pls_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]  o_count
);

    logic [CNT_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_entry_count;
    logic [CNT_W-1:0]  n_entry_count;
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_read_value;
    logic [CNT_W-1:0]  r_count;

    logic              w_accept;
    logic              w_full;
    logic              w_in_range;
    logic              w_rd_ok;
    logic              w_ins_ok;
    logic              w_rem_ok;
    logic              w_ok;
    logic [DATA_W-1:0] w_rd_data;
    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_sel  [DEPTH];

    // Nothing is taken while reset is held.
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full     = (32'(r_entry_count) >= 32'(r_capacity)) ||
                        (32'(r_entry_count) >= DEPTH);
    assign w_in_range = (i_position < r_entry_count);

    always_comb begin
        w_rd_ok  = 1'b0;
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        case (i_func)
            FUNC_READ:   w_rd_ok  = w_in_range;
            FUNC_INSERT: w_ins_ok = (i_position <= r_entry_count) && !w_full;
            FUNC_REMOVE: w_rem_ok = w_in_range;
            default: begin
            end
        endcase
    end

    assign w_ok = w_rd_ok || w_ins_ok || w_rem_ok;

    always_comb begin
        w_ctl.ins      = w_accept && w_ins_ok;
        w_ctl.rem      = w_accept && w_rem_ok;
        w_ctl.position = i_position;
        w_ctl.value    = i_value;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end
        pls_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .o_data      (w_data[g]),
            .o_sel_data  (w_sel[g])
        );
    end

    // Only the cell at the requested position drives a nonzero word.
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | w_sel[k];
        end
    end

    always_comb begin
        n_entry_count = r_entry_count;
        if (w_ctl.ins) begin
            n_entry_count = r_entry_count + 1'b1;
        end else if (w_ctl.rem) begin
            n_entry_count = r_entry_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= CAP_RESET;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_entry_count <= n_entry_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok         <= w_ok;
            r_read_value <= w_rd_ok ? w_rd_data : '0;
            r_count      <= n_entry_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_read_value;
    assign o_count      = r_count;

endmodule

/* hw/rtl/pls_checker.sv */
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store_unit.
module pls_checker import pls_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_ok,
    input logic [DATA_W-1:0] o_read_value,
    input logic [CNT_W-1:0]  o_count
);

    // No result may be pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_ok) && $stable(o_read_value) && $stable(o_count))
        else $error("stalled result changed");

    // A refused item never carries read data.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_read_value == '0)
        else $error("refused item carries read data");

    // The input side only stalls behind a result that is not taken.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind positional_list_store_unit pls_checker u_pls_checker (.*);
